>>> sv/lnws_pkg.sv
// ----------------------------------------------------------------------------
// lnws_pkg
// Types and constants shared by the 4-bit display write sequencer.
// ----------------------------------------------------------------------------
package lnws_pkg;

	localparam int unsigned WAIT_W = 7;
	localparam logic [WAIT_W-1:0] SLOW_WAIT_RESET = 7'd32;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HIGH  = 3'd1,
		PH_STRB1 = 3'd2,
		PH_LOW   = 3'd3,
		PH_STRB2 = 3'd4
	} phase_t;

	typedef struct packed {
		logic       queue_ready;
		logic [7:0] char_byte;
		logic       is_command;
		logic       slow_command;
	} tick_word_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       reg_select;
		logic       enable_pin;
		logic       bus_drive;
		logic       take_byte;
		logic       byte_done;
		logic       fast_period;
	} pin_word_t;

endpackage

>>> sv/lnws_tick_if.sv
// ----------------------------------------------------------------------------
// lnws_tick_if
// Valid/ready channel carrying one sequencer tick word.
// ----------------------------------------------------------------------------
interface lnws_tick_if;
	import lnws_pkg::*;

	logic       valid;
	logic       ready;
	tick_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

>>> sv/lnws_pin_if.sv
// ----------------------------------------------------------------------------
// lnws_pin_if
// Valid/ready channel carrying one pin/status result word.
// ----------------------------------------------------------------------------
interface lnws_pin_if;
	import lnws_pkg::*;

	logic      valid;
	logic      ready;
	pin_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

>>> sv/lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer
// Drives a 4-bit character display bus: tick by tick, latch a queued byte, put out
// the high nibble, strobe, low nibble, strobe, release, with optional hold
// after slow commands.
//
//   channel   dir  payload       handshake
//   tick      in   tick_word_t   valid/ready
//   pins      out  pin_word_t    valid/ready
//   cfg       in   7-bit limit   cfg_we (write only)
//
// A tick word is registered on acceptance, then its result word is registered
// in the output register; one tick per cycle is sustained while pins is ready.
// The sequencer state and the output register advance together, so a stall
// on pins holds at most one pending tick in the input register.
// Reset clears the state and the output valid flag (not the pin word) and sets the limit to 32.
// ----------------------------------------------------------------------------
module lcd_nibble_write_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lnws_pkg::WAIT_W-1:0]    cfg_wdata,
	lnws_tick_if.sink                      tick,
	lnws_pin_if.source                     pins
);
	import lnws_pkg::*;

	logic              slow_wait_q;
	logic [WAIT_W-1:0] limit_q;

	logic       valid_s1;
	tick_word_t word_s1;

	logic       out_valid_q;
	pin_word_t  out_word_q;

	phase_t      phase_q, phase_d;
	logic [3:0]  held_lo_q, held_lo_d;
	logic        skip_q, skip_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [3:0]  nibble_q, nibble_d;
	logic        select_q, select_d;
	logic        enable_q, enable_d;
	logic        drive_q, drive_d;
	logic        slow_wait_d;
	logic        took, done, fast;

	logic advance;

	assign advance    = !out_valid_q || pins.ready;
	assign tick.ready = !valid_s1 || advance;

	assign pins.valid = out_valid_q;
	assign pins.data  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SLOW_WAIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			word_s1 <= tick.data;
		end
	end

	// next state for the registered tick
	always_comb begin
		phase_d     = phase_q;
		held_lo_d   = held_lo_q;
		skip_d      = skip_q;
		wait_d      = wait_q;
		nibble_d    = nibble_q;
		select_d    = select_q;
		enable_d    = enable_q;
		drive_d     = drive_q;
		slow_wait_d = slow_wait_q;
		took        = 1'b0;
		done        = 1'b0;
		fast        = 1'b0;
		if (word_s1.queue_ready || phase_q != PH_IDLE) begin
			case (phase_q)
				PH_IDLE: begin
					held_lo_d   = word_s1.char_byte[3:0];
					slow_wait_d = word_s1.slow_command;
					skip_d      = 1'b0;
					drive_d     = 1'b1;
					nibble_d    = word_s1.char_byte[7:4];
					select_d    = !word_s1.is_command;
					took        = 1'b1;
					phase_d     = PH_HIGH;
				end
				PH_HIGH: begin
					enable_d = 1'b1;
					phase_d  = PH_STRB1;
				end
				PH_STRB1: begin
					enable_d = 1'b0;
					nibble_d = held_lo_q;
					phase_d  = PH_LOW;
				end
				PH_LOW: begin
					enable_d = 1'b1;
					phase_d  = PH_STRB2;
				end
				default: begin
					if (phase_q == PH_STRB2 && !skip_q) begin
						enable_d = 1'b0;
						drive_d  = 1'b0;
						done     = 1'b1;
					end
					// slow command hold
					if (slow_wait_q) begin
						skip_d = 1'b1;
						if (wait_q >= limit_q) begin
							slow_wait_d = 1'b0;
							wait_d      = '0;
						end else begin
							wait_d = wait_q + 1'b1;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
			fast = !slow_wait_d;
		end else begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			held_lo_q   <= '0;
			skip_q      <= 1'b0;
			wait_q      <= '0;
			nibble_q    <= '0;
			select_q    <= 1'b0;
			enable_q    <= 1'b0;
			drive_q     <= 1'b0;
			slow_wait_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_d;
			held_lo_q   <= held_lo_d;
			skip_q      <= skip_d;
			wait_q      <= wait_d;
			nibble_q    <= nibble_d;
			select_q    <= select_d;
			enable_q    <= enable_d;
			drive_q     <= drive_d;
			slow_wait_q <= slow_wait_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_word_q.data_nibble <= nibble_d;
			out_word_q.reg_select  <= select_d;
			out_word_q.enable_pin  <= enable_d;
			out_word_q.bus_drive   <= drive_d;
			out_word_q.take_byte   <= took;
			out_word_q.byte_done   <= done;
			out_word_q.fast_period <= fast;
		end
	end

endmodule
